// ----- src/fpfs_pkg.sv -----
// Shared types, constants and helper functions for the fan power solver.
// No dependencies; every other file but fpfs_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fpfs_pkg;

    // Full scale power, 100 percent in Q7.16.
    localparam logic [22:0] FULL_POWER = 23'd6553600;
    // Largest outlet flow, Q12.8.
    localparam logic [19:0] FLOW_MAX   = 20'hFFFFF;
    // Reciprocals for division by 5 and by 50, scaled by 2^32 and rounded up.
    localparam logic [31:0] RECIP5     = 32'd858993460;
    localparam logic [31:0] RECIP50    = 32'd85899346;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_CURVES_M100  = 3'd0,
        CFG_CURVES_M50   = 3'd1,
        CFG_CURVES_ZERO  = 3'd2,
        CFG_FLOW_PER_VEL = 3'd3,
        CFG_MIN_POWER    = 3'd4,
        CFG_MAX_POWER    = 3'd5
    } cfg_index_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NONE        = 3'd1,
        ST_BELOW       = 3'd2,
        ST_EXTRAP      = 3'd3,
        ST_UNREACHABLE = 3'd4
    } status_t;

    // Curve set seen by every cell: index 0 is gate -100, 1 is -50, 2 is 0.
    typedef struct packed {
        logic [2:0][63:0] curves;
        logic [15:0]      flow_per_velocity;
    } curve_cfg_t;

    // Item context that travels down the chain of bisection cells.
    typedef struct packed {
        logic              valid;
        logic [19:0]       target;
        logic signed [7:0] gate;
        logic [22:0]       low;
        logic [22:0]       high;
        logic [22:0]       mid;
        logic              unreach;
    } cell_ctx_t;

    // One result item.
    typedef struct packed {
        logic [22:0] fan_power;
        status_t     solve_status;
    } result_t;

    // Entry idx of the exp table: exp(-step*idx), Q0.16, with the step
    // factor given as Q0.32 input y (16 / depth). Elaboration only.
    function automatic logic [16:0] exp_entry(input int unsigned idx, input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] cur;
        logic [63:0] r;
        int unsigned n;
        term = 64'd1 << 32;
        acc  = term;
        for (n = 1; n < 20; n++)
        begin
            term = ((term * y) >> 32) / 64'(n);
            if (n[0])
                acc = acc - term;
            else
                acc = acc + term;
        end
        cur = 64'd1 << 32;
        for (n = 0; n < idx; n++)
        begin
            cur = (cur * acc) >> 32;
        end
        r = (cur + 64'd32768) >> 16;
        return (r > 64'd65536) ? 17'd65536 : r[16:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/fpfs_if.sv -----
// Valid/ready channel interfaces for request and result items.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface fpfs_req_if;
    logic              valid;
    logic              ready;
    logic [19:0]       target_flow;
    logic signed [7:0] gate_position;
    modport source (output valid, output target_flow, output gate_position, input ready);
    modport sink   (input valid, input target_flow, input gate_position, output ready);
endinterface

interface fpfs_res_if;
    logic        valid;
    logic        ready;
    logic [22:0] fan_power;
    logic [2:0]  solve_status;
    modport source (output valid, output fan_power, output solve_status, input ready);
    modport sink   (input valid, input fan_power, input solve_status, output ready);
endinterface

`default_nettype wire

// ----- src/fpfs_cell.sv -----
// One bisection cell: evaluates the total modelled flow at one power and
// updates the bracket. Eight register stages. Depends on fpfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpfs_cell
    import fpfs_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256,
    parameter bit CHECK_CELL      = 1'b0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      adv,
    input  wire curve_cfg_t cfg,
    input  wire cell_ctx_t ctx_in,
    output cell_ctx_t      ctx_out
);

    localparam int IDX_W = (EXP_TABLE_DEPTH > 1) ? $clog2(EXP_TABLE_DEPTH) : 1;
    localparam logic [63:0] EXP_STEP = (64'd16 << 32) / 64'(EXP_TABLE_DEPTH);

    // Constant exp table, evaluated at elaboration.
    logic [16:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++)
    begin : g_rom
        localparam logic [16:0] EV = exp_entry(gi, EXP_STEP);
        assign exp_rom[gi] = EV;
    end

    // Context pipeline, one entry per stage.
    cell_ctx_t ctx_reg [8];
    cell_ctx_t ctx_next [8];

    logic [38:0]      kp_reg [6];
    logic [38:0]      kp_next [6];
    logic [IDX_W-1:0] idx_reg [6];
    logic [IDX_W-1:0] idx_next [6];
    logic             idx_ok_reg [6];
    logic             idx_ok_next [6];
    logic [32:0]      am_reg [6];
    logic [32:0]      am_next [6];
    logic [19:0]      flow_reg [6];
    logic [19:0]      flow_next [6];
    logic [19:0]      flow4_reg [6];
    logic [19:0]      p50_reg [2];
    logic [19:0]      p50_next [2];
    logic [25:0]      blend_reg [2];
    logic [25:0]      blend_next [2];
    logic [19:0]      q_reg [2];
    logic [19:0]      q_next [2];

    // Stage 0: choose the probe power and form k * p for every outlet.
    always_comb
    begin
        logic [23:0] sum;
        ctx_next[0] = ctx_in;
        sum = 24'(ctx_in.low) + 24'(ctx_in.high);
        if (CHECK_CELL)
            ctx_next[0].mid = FULL_POWER;
        else
            ctx_next[0].mid = sum[23:1];
        for (int j = 0; j < 6; j++)
        begin
            kp_next[j] = 39'(cfg.curves[j / 2][(j % 2) * 32 + 16 +: 16])
                       * 39'(ctx_next[0].mid);
        end
    end

    // Stage 1: scale to the table index and range check it.
    always_comb
    begin
        logic [63:0] scaled;
        logic [63:0] idx_full;
        ctx_next[1] = ctx_reg[0];
        for (int j = 0; j < 6; j++)
        begin
            scaled         = 64'(kp_reg[j]) * 64'(EXP_TABLE_DEPTH);
            idx_full       = scaled >> 36;
            idx_ok_next[j] = idx_full < 64'(EXP_TABLE_DEPTH);
            idx_next[j]    = idx_full[IDX_W-1:0];
        end
    end

    // Stage 2: table lookup and a * (1 - e).
    always_comb
    begin
        logic [16:0] e;
        ctx_next[2] = ctx_reg[1];
        for (int j = 0; j < 6; j++)
        begin
            e = idx_ok_reg[j] ? exp_rom[idx_reg[j]] : 17'd0;
            am_next[j] = 33'(cfg.curves[j / 2][(j % 2) * 32 +: 16])
                       * 33'(17'd65536 - e);
        end
    end

    // Stage 3: times the velocity scale, then saturate.
    always_comb
    begin
        logic [48:0] v;
        logic [28:0] vs;
        ctx_next[3] = ctx_reg[2];
        for (int j = 0; j < 6; j++)
        begin
            v  = 49'(am_reg[j]) * 49'(cfg.flow_per_velocity);
            vs = v[48:20];
            flow_next[j] = (vs > 29'(FLOW_MAX)) ? FLOW_MAX : vs[19:0];
        end
    end

    // Stage 4: the mirrored +50 point, with its outlets swapped.
    always_comb
    begin
        logic [22:0] x1;
        logic [22:0] x2;
        logic [63:0] pr1;
        logic [63:0] pr2;
        ctx_next[4] = ctx_reg[3];
        x1 = 23'(flow_reg[3]) * 23'd3 + 23'(flow_reg[5]) * 23'd2;
        x2 = 23'(flow_reg[2]) * 23'd3 + 23'(flow_reg[4]) * 23'd2;
        pr1 = 64'(x1) * 64'(RECIP5);
        pr2 = 64'(x2) * 64'(RECIP5);
        p50_next[0] = pr1[51:32];
        p50_next[1] = pr2[51:32];
    end

    // Stage 5: pick the bracketing points and weight them.
    always_comb
    begin
        logic signed [8:0] gs;
        logic signed [8:0] nw;
        logic [5:0]  n;
        logic [19:0] lo [2];
        logic [19:0] hi [2];
        ctx_next[5] = ctx_reg[4];
        gs = 9'(ctx_reg[4].gate);
        if (gs <= -9'sd50)
        begin
            nw = gs + 9'sd100;
            lo[0] = flow4_reg[0]; lo[1] = flow4_reg[1];
            hi[0] = flow4_reg[2]; hi[1] = flow4_reg[3];
        end
        else if (gs <= 9'sd0)
        begin
            nw = gs + 9'sd50;
            lo[0] = flow4_reg[2]; lo[1] = flow4_reg[3];
            hi[0] = flow4_reg[4]; hi[1] = flow4_reg[5];
        end
        else if (gs <= 9'sd50)
        begin
            nw = gs;
            lo[0] = flow4_reg[4]; lo[1] = flow4_reg[5];
            hi[0] = p50_reg[0];   hi[1] = p50_reg[1];
        end
        else
        begin
            nw = gs - 9'sd50;
            lo[0] = p50_reg[0];   lo[1] = p50_reg[1];
            hi[0] = flow4_reg[1]; hi[1] = flow4_reg[0];
        end
        n = nw[5:0];
        for (int o = 0; o < 2; o++)
        begin
            blend_next[o] = 26'(lo[o]) * 26'(6'd50 - n) + 26'(hi[o]) * 26'(n);
        end
    end

    // Stage 6: divide each weighted sum by 50.
    always_comb
    begin
        logic [63:0] pr;
        ctx_next[6] = ctx_reg[5];
        for (int o = 0; o < 2; o++)
        begin
            pr = 64'(blend_reg[o]) * 64'(RECIP50);
            q_next[o] = pr[51:32];
        end
    end

    // Stage 7: compare total flow to target; move bracket or flag unreach.
    always_comb
    begin
        logic [20:0] total;
        ctx_next[7] = ctx_reg[6];
        total = 21'(q_reg[0]) + 21'(q_reg[1]);
        if (CHECK_CELL)
            ctx_next[7].unreach = 21'(ctx_reg[6].target) > total;
        else if (total < 21'(ctx_reg[6].target))
            ctx_next[7].low = ctx_reg[6].mid;
        else
            ctx_next[7].high = ctx_reg[6].mid;
    end

    // Context registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 8; s++)
                ctx_reg[s] <= '0;
        end
        else if (adv)
        begin
            for (int s = 0; s < 8; s++)
                ctx_reg[s] <= ctx_next[s];
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 6; j++)
            begin
                kp_reg[j]     <= kp_next[j];
                idx_reg[j]    <= idx_next[j];
                idx_ok_reg[j] <= idx_ok_next[j];
                am_reg[j]     <= am_next[j];
                flow_reg[j]   <= flow_next[j];
                flow4_reg[j]  <= flow_reg[j];
            end
            for (int o = 0; o < 2; o++)
            begin
                p50_reg[o]   <= p50_next[o];
                blend_reg[o] <= blend_next[o];
                q_reg[o]     <= q_next[o];
            end
        end
    end

    assign ctx_out = ctx_reg[7];

endmodule

`default_nettype wire

// ----- src/fpfs_out_fifo.sv -----
// Two-entry result queue that decouples the cell chain from the consumer.
// Depends on fpfs_pkg and fpfs_if.
`timescale 1ns / 1ps
`default_nettype none

module fpfs_out_fifo
    import fpfs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         space,
    fpfs_res_if.source   res
);

    result_t    mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop   = res.valid && res.ready;
    assign space = count_reg < 2'd2;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    assign res.valid        = count_reg != 2'd0;
    assign res.fan_power    = mem_reg[rptr_reg].fan_power;
    assign res.solve_status = mem_reg[rptr_reg].solve_status;

endmodule

`default_nettype wire

// ----- src/fan_power_for_flow_solver_unit.sv -----
// Top level of the fan power solver: configuration registers, the chain of
// bisection cells and the result queue. Depends on fpfs_pkg, fpfs_if,
// fpfs_cell and fpfs_out_fifo.
//
//   Channel  Dir  Handshake        Payload
//   req      in   valid/ready      target_flow[19:0], gate_position[7:0] signed
//   res      out  valid/ready      fan_power[22:0], solve_status[2:0]
//   cfg      in   cfg_we           cfg_index[2:0], cfg_data[63:0]
//
// One item enters per cycle while the result queue has space. Items reach
// the queue through one full-power check cell and one cell per bisection
// step, eight register stages each, set by the exp lookup and multiply chain.
// Reset clears the control and config registers; no clearing pass is needed.
// The whole chain holds only while the two-entry result queue is full.
`timescale 1ns / 1ps
`default_nettype none

module fan_power_for_flow_solver_unit
    import fpfs_pkg::*;
#(
    parameter int BISECTION_STEPS = 20,
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    fpfs_req_if.sink         req,
    fpfs_res_if.source       res
);

    curve_cfg_t  cfg_reg;
    logic [22:0] min_power_reg;
    logic [22:0] max_power_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            min_power_reg <= 23'd0;
            max_power_reg <= FULL_POWER;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_CURVES_M100:  cfg_reg.curves[0] <= cfg_data;
                CFG_CURVES_M50:   cfg_reg.curves[1] <= cfg_data;
                CFG_CURVES_ZERO:  cfg_reg.curves[2] <= cfg_data;
                CFG_FLOW_PER_VEL: cfg_reg.flow_per_velocity <= cfg_data[15:0];
                CFG_MIN_POWER:    min_power_reg <= cfg_data[22:0];
                CFG_MAX_POWER:    max_power_reg <= cfg_data[22:0];
                default:          ;
            endcase
        end
    end

    logic      adv;
    cell_ctx_t chain [BISECTION_STEPS + 2];

    assign req.ready = adv;

    // Incoming item with the gate clamped to -100..100.
    always_comb
    begin
        chain[0]         = '0;
        chain[0].valid   = req.valid;
        chain[0].target  = req.target_flow;
        chain[0].high    = FULL_POWER;
        if (req.gate_position < -8'sd100)
            chain[0].gate = -8'sd100;
        else if (req.gate_position > 8'sd100)
            chain[0].gate = 8'sd100;
        else
            chain[0].gate = req.gate_position;
    end

    // Full-power check cell followed by the bisection cells.
    for (genvar gc = 0; gc <= BISECTION_STEPS; gc++)
    begin : g_cell
        fpfs_cell #(
            .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
            .CHECK_CELL      (gc == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .cfg     (cfg_reg),
            .ctx_in  (chain[gc]),
            .ctx_out (chain[gc + 1])
        );
    end

    // Final answer and status from the last bracket.
    result_t   result;
    cell_ctx_t last;
    assign last = chain[BISECTION_STEPS + 1];

    always_comb
    begin
        logic [23:0] sum;
        sum = 24'(last.low) + 24'(last.high);
        result.fan_power = sum[23:1];
        if (last.target == 20'd0)
        begin
            result.fan_power    = 23'd0;
            result.solve_status = ST_NONE;
        end
        else if (last.unreach)
        begin
            result.fan_power    = FULL_POWER;
            result.solve_status = ST_UNREACHABLE;
        end
        else if (sum[23:1] < min_power_reg)
            result.solve_status = ST_BELOW;
        else if (sum[23:1] > max_power_reg)
            result.solve_status = ST_EXTRAP;
        else
            result.solve_status = ST_OK;
    end

    fpfs_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (last.valid && adv),
        .push_data (result),
        .space     (adv),
        .res       (res)
    );

endmodule

`default_nettype wire

// ----- src/fpfs_checker.sv -----
// Port-level checks on the result channel of the fan power solver, and the
// bind that attaches them to the top level. Depends on fpfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpfs_checker
    import fpfs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [22:0] fan_power,
    input wire logic [2:0]  solve_status
);

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(fan_power) && $stable(solve_status))
        else $error("result item changed while stalled");

    // An unreachable target always reports full power.
    a_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && solve_status == ST_UNREACHABLE |-> fan_power == FULL_POWER)
        else $error("unreachable status without full power");

    // A zero request always reports zero power.
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && solve_status == ST_NONE |-> fan_power == 23'd0)
        else $error("no-request status with nonzero power");

    // Power never exceeds full scale and status stays within its codes.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> fan_power <= FULL_POWER && solve_status <= ST_UNREACHABLE)
        else $error("result out of range");

endmodule

bind fan_power_for_flow_solver_unit fpfs_checker u_fpfs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .fan_power    (res.fan_power),
    .solve_status (res.solve_status)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the fan power solver: random and directed solve
// requests, a built-in fixed-point solver for the expected results, random stalls.
// Depends on fpfs_pkg, fpfs_if and fan_power_for_flow_solver_unit.
`timescale 1ns / 1ps

module tb;
    import fpfs_pkg::*;

    localparam int STEPS        = 20;
    localparam int EXP_DEPTH    = 256;
    localparam int LATENCY      = 8 * (STEPS + 1) + 1;
    localparam int WATCHDOG_MAX = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [2:0] CFG_SPARE6 = 3'd6;
    localparam logic [2:0] CFG_SPARE7 = 3'd7;

    typedef struct packed {
        logic [19:0]       target;
        logic signed [7:0] gate;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    fpfs_req_if req ();
    fpfs_res_if res ();

    fan_power_for_flow_solver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .res       (res.source)
    );

    // Shadow copy of the configuration registers.
    logic [2:0][63:0] curve_regs;
    logic [15:0]      scale_reg;
    logic [22:0]      min_power_reg;
    logic [22:0]      max_power_reg;
    logic [16:0]      exp_lut [EXP_DEPTH];

    request_t pending_requests [$];
    result_t  expected_results [$];
    int       mismatches;
    int       sent_items;
    int       returned_items;
    int       quiet_cycles;
    bit       hold_done;
    int       hold_left;

    // Steady stretch: neither side idles at random while these items go through.
    function automatic bit steady();
        return sent_items >= 150 && sent_items < 300;
    endfunction

    always #5 clk = ~clk;

    // Table of exp(-16*i/depth), Q0.16, by series for the step and repeated products.
    function automatic void fill_exp_lut();
        logic [63:0] step_y;
        logic [63:0] term;
        logic [63:0] factor;
        logic [63:0] run;
        logic [63:0] rounded;
        step_y = (64'd16 << 32) / EXP_DEPTH;
        term = 64'd1 << 32;
        factor = term;
        for (int n = 1; n < 20; n++)
        begin
            term = ((term * step_y) >> 32) / n;
            factor = (n % 2 == 1) ? factor - term : factor + term;
        end
        run = 64'd1 << 32;
        for (int i = 0; i < EXP_DEPTH; i++)
        begin
            rounded = (run + 64'h8000) >> 16;
            exp_lut[i] = (rounded > 64'd65536) ? 17'd65536 : rounded[16:0];
            run = (run * factor) >> 32;
        end
    endfunction

    // Flow of one outlet at power p, Q12.8, saturated.
    function automatic logic [63:0] outlet_flow(logic [15:0] a, logic [15:0] k, logic [22:0] p);
        logic [63:0] idx;
        logic [63:0] e;
        logic [63:0] v;
        if (p == 0)
            return 0;
        if (p > FULL_POWER)
            p = FULL_POWER;
        idx = (64'(k) * 64'(p) * EXP_DEPTH) >> 36;
        e = (idx < EXP_DEPTH) ? 64'(exp_lut[idx]) : 64'd0;
        v = (64'(a) * (64'd65536 - e) * 64'(scale_reg)) >> 20;
        return (v > 64'(FLOW_MAX)) ? 64'(FLOW_MAX) : v;
    endfunction

    // Total flow at power p for a clamped gate, blending the calibrated curves.
    function automatic logic [63:0] gate_flow(logic [22:0] p, int gate);
        logic [63:0] f1 [3];
        logic [63:0] f2 [3];
        logic [63:0] lo1, lo2, hi1, hi2, m1, m2;
        int n;
        if (p == 0)
            return 0;
        for (int c = 0; c < 3; c++)
        begin
            f1[c] = outlet_flow(curve_regs[c][15:0], curve_regs[c][31:16], p);
            f2[c] = outlet_flow(curve_regs[c][47:32], curve_regs[c][63:48], p);
        end
        // The +50 point is the -30 point with outlets swapped.
        m1 = (f2[1] * 3 + f2[2] * 2) / 5;
        m2 = (f1[1] * 3 + f1[2] * 2) / 5;
        if (gate <= -50)
        begin
            lo1 = f1[0]; lo2 = f2[0]; hi1 = f1[1]; hi2 = f2[1]; n = gate + 100;
        end
        else if (gate <= 0)
        begin
            lo1 = f1[1]; lo2 = f2[1]; hi1 = f1[2]; hi2 = f2[2]; n = gate + 50;
        end
        else if (gate <= 50)
        begin
            lo1 = f1[2]; lo2 = f2[2]; hi1 = m1; hi2 = m2; n = gate;
        end
        else
        begin
            lo1 = m1; lo2 = m2; hi1 = f2[0]; hi2 = f1[0]; n = gate - 50;
        end
        return (lo1 * (50 - n) + hi1 * n) / 50 + (lo2 * (50 - n) + hi2 * n) / 50;
    endfunction

    // Expected result of one request.
    function automatic result_t solve_power(request_t r);
        result_t     o;
        int          gate;
        logic [22:0] low;
        logic [22:0] high;
        logic [22:0] mid;
        gate = r.gate;
        if (gate < -100) gate = -100;
        if (gate > 100) gate = 100;
        low = 0;
        high = FULL_POWER;
        if (r.target == 0)
        begin
            o.fan_power = 0;
            o.solve_status = ST_NONE;
        end
        else if (64'(r.target) > gate_flow(FULL_POWER, gate))
        begin
            o.fan_power = FULL_POWER;
            o.solve_status = ST_UNREACHABLE;
        end
        else
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                mid = 23'((24'(low) + 24'(high)) >> 1);
                if (gate_flow(mid, gate) < 64'(r.target))
                    low = mid;
                else
                    high = mid;
            end
            o.fan_power = 23'((24'(low) + 24'(high)) >> 1);
            if (o.fan_power < min_power_reg)
                o.solve_status = ST_BELOW;
            else if (o.fan_power > max_power_reg)
                o.solve_status = ST_EXTRAP;
            else
                o.solve_status = ST_OK;
        end
        return o;
    endfunction

    // Request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
            req.valid <= 1'b0;
        else if (!req.valid || req.ready)
        begin
            if (pending_requests.size() > 0 && (steady() || $urandom_range(0, 99) >= 11))
            begin
                request_t r;
                r = pending_requests.pop_front();
                req.valid <= 1'b1;
                req.target_flow <= r.target;
                req.gate_position <= r.gate;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Prediction of every accepted request.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            request_t r;
            r.target = req.target_flow;
            r.gate = req.gate_position;
            expected_results.push_back(solve_power(r));
            sent_items <= sent_items + 1;
        end
    end

    // Result receiver, with one long hold-off after the first hundred results.
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else if (!hold_done && returned_items >= 100)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            res.ready <= 1'b0;
        end
        else
            res.ready <= steady() || $urandom_range(0, 99) >= 11;
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            result_t e;
            returned_items <= returned_items + 1;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item: fan_power %0d solve_status %0d",
                       res.fan_power, res.solve_status);
                mismatches++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (res.fan_power !== e.fan_power)
                begin
                    $error("fan_power expected %0d actual %0d", e.fan_power, res.fan_power);
                    mismatches++;
                end
                if (res.solve_status !== e.solve_status)
                begin
                    $error("solve_status expected %0d actual %0d",
                           e.solve_status, res.solve_status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_CURVES_M100:  curve_regs[0] = value;
            CFG_CURVES_M50:   curve_regs[1] = value;
            CFG_CURVES_ZERO:  curve_regs[2] = value;
            CFG_FLOW_PER_VEL: scale_reg = value[15:0];
            CFG_MIN_POWER:    min_power_reg = value[22:0];
            CFG_MAX_POWER:    max_power_reg = value[22:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic add_request(logic [19:0] target, int gate);
        request_t r;
        r.target = target;
        r.gate = 8'(gate);
        pending_requests.push_back(r);
    endtask

    task automatic add_random(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            add_request(pick < 4 ? 20'd0 :
                        pick < 14 ? 20'($urandom) : 20'($urandom_range(1, 200000)),
                        $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) - 128
                                                  : $urandom_range(0, 200) - 100);
        end
    endtask

    // Random but plausible curve: a up to ~15.6 m/s, k spread around 0.03 per percent.
    function automatic logic [63:0] random_curves();
        return {16'($urandom_range(200, 8000)), 16'($urandom_range(0, 4000)),
                16'($urandom_range(200, 8000)), 16'($urandom_range(0, 4000))};
    endfunction

    initial
    begin
        int gates [14] = '{-128, -101, -100, -75, -50, -30, -1, 0, 1, 25, 50, 51, 100, 127};
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CURVES_M100;
        cfg_data = '0;
        req.valid = 1'b0;
        req.target_flow = '0;
        req.gate_position = '0;
        res.ready = 1'b0;
        mismatches = 0;
        sent_items = 0;
        returned_items = 0;
        quiet_cycles = 0;
        hold_done = 1'b0;
        hold_left = 0;
        curve_regs = '0;
        scale_reg = '0;
        min_power_reg = '0;
        max_power_reg = FULL_POWER;
        fill_exp_lut();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: every curve is flat, so only a zero target is reachable.
        add_request(20'd0, 0);
        add_request(20'd1, -100);
        add_request(20'hFFFFF, 127);
        drain();

        // Realistic curves with a calibrated window of 10 to 90 percent.
        write_reg(CFG_CURVES_M100, {16'd1966, 16'd1280, 16'd2600, 16'd900});
        write_reg(CFG_CURVES_M50, {16'd2300, 16'd1100, 16'd1800, 16'd1200});
        write_reg(CFG_CURVES_ZERO, {16'd3000, 16'd700, 16'd1500, 16'd1500});
        write_reg(CFG_FLOW_PER_VEL, 64'd960);
        write_reg(CFG_MIN_POWER, 64'd655360);
        write_reg(CFG_MAX_POWER, 64'd5898240);
        foreach (gates[i])
            add_request(20'($urandom_range(1000, 120000)), gates[i]);
        add_request(20'd0, 50);
        add_request(20'd1, 0);
        add_request(20'd2000, -50);
        add_request(20'd140000, 100);
        add_request(20'hFFFFF, -100);
        add_request(20'h80000, 0);
        add_random(400);
        drain();

        // Extremes: full curves, full scale, min above max, spare indexes.
        write_reg(CFG_CURVES_M100, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CURVES_M50, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CURVES_ZERO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_FLOW_PER_VEL, 64'hFFFF);
        write_reg(CFG_MIN_POWER, 64'(FULL_POWER));
        write_reg(CFG_MAX_POWER, 64'd0);
        write_reg(CFG_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SPARE7, 64'h1234_5678_9ABC_DEF0);
        add_request(20'hFFFFF, -100);
        add_request(20'd1, 100);
        add_random(60);
        drain();

        // Random curves and scale, full calibrated window.
        write_reg(CFG_CURVES_M100, random_curves());
        write_reg(CFG_CURVES_M50, random_curves());
        write_reg(CFG_CURVES_ZERO, random_curves());
        write_reg(CFG_FLOW_PER_VEL, 64'($urandom_range(200, 2000)));
        write_reg(CFG_MIN_POWER, 64'd0);
        write_reg(CFG_MAX_POWER, 64'(FULL_POWER));
        add_random(100);
        drain();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
